// ===== rtl/gobm_pkg.sv =====
// Shared types and constants of the grid outer border marker.
// Used by every module under rtl/; depends on nothing else.
package gobm_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 256;
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned CNT_W         = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CFG_AW        = 3;
  localparam int unsigned CFG_DW        = 32;
  localparam int unsigned SIZE_W        = 9;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 9'd175;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 9'd175;
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd3;
  localparam logic [SIZE_W-1:0] HEIGHT_MAX = 9'd256;

  localparam logic [3:0] WALL_CODE  = 4'd5;
  localparam logic [3:0] EMPTY_CODE = 4'd0;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [3:0] cell_req;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0] out_row;
    logic [7:0] out_col;
    logic [3:0] out_cell;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [SIZE_W-1:0] grid_width;
    logic [SIZE_W-1:0] grid_height;
  } cfg_t;

  // Results of one item handed to the output queue in a single cycle.
  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } push_t;

endpackage

// ===== rtl/gobm_regs.sv =====
// Configuration registers of the grid outer border marker, APB-style port.
// Depends on gobm_pkg.
module gobm_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gobm_pkg::CFG_AW-1:0] paddr,
  input  logic [gobm_pkg::CFG_DW-1:0] pwdata,
  output logic [gobm_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output gobm_pkg::cfg_t              cfg_o
);

  logic [gobm_pkg::SIZE_W-1:0] width_q;
  logic [gobm_pkg::SIZE_W-1:0] height_q;
  logic                        wr_en;
  gobm_pkg::reg_idx_e          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = gobm_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gobm_pkg::WIDTH_RST;
      height_q <= gobm_pkg::HEIGHT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        gobm_pkg::REG_GRID_WIDTH:  width_q  <= pwdata[gobm_pkg::SIZE_W-1:0];
        gobm_pkg::REG_GRID_HEIGHT: height_q <= pwdata[gobm_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gobm_pkg::REG_GRID_WIDTH:
        prdata = {{(gobm_pkg::CFG_DW-gobm_pkg::SIZE_W){1'b0}}, width_q};
      gobm_pkg::REG_GRID_HEIGHT:
        prdata = {{(gobm_pkg::CFG_DW-gobm_pkg::SIZE_W){1'b0}}, height_q};
      default:
        prdata = '0;
    endcase
  end

  assign cfg_o.grid_width  = width_q;
  assign cfg_o.grid_height = height_q;

endmodule

// ===== rtl/gobm_scan.sv =====
// Raster position counters, line buffer memory, 3x3 window and marking logic.
// Depends on gobm_pkg; feeds its results to gobm_out_fifo.
module gobm_scan #(
  parameter int unsigned MAX_WIDTH = gobm_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gobm_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  input  gobm_pkg::in_t              in_data_i,
  output logic                       in_stall_o,
  input  logic [gobm_pkg::CNT_W-1:0] fifo_cnt_i,
  output gobm_pkg::push_t            push_o
);

  localparam int unsigned MemDepth = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam logic [gobm_pkg::SIZE_W-1:0] WidthMax = gobm_pkg::SIZE_W'(MemDepth);
  localparam logic [7:0] ColLimit = 8'(MemDepth - 1);
  localparam logic [gobm_pkg::CNT_W:0] RoomLimit =
    (gobm_pkg::CNT_W + 1)'(gobm_pkg::FIFO_DEPTH - 2);

  // Effective grid size.
  logic [gobm_pkg::SIZE_W-1:0] w_eff, h_eff;
  logic [7:0] wm1, hm1;

  always_comb begin
    if (cfg_i.grid_width < gobm_pkg::SIZE_MIN)  w_eff = gobm_pkg::SIZE_MIN;
    else if (cfg_i.grid_width > WidthMax)       w_eff = WidthMax;
    else                                        w_eff = cfg_i.grid_width;
    if (cfg_i.grid_height < gobm_pkg::SIZE_MIN) h_eff = gobm_pkg::SIZE_MIN;
    else if (cfg_i.grid_height > gobm_pkg::HEIGHT_MAX) h_eff = gobm_pkg::HEIGHT_MAX;
    else                                        h_eff = cfg_i.grid_height;
  end

  assign wm1 = 8'(w_eff - 9'd1);
  assign hm1 = 8'(h_eff - 9'd1);

  // Position stage.
  logic [7:0] row_q, row_d, col_q, col_d;
  logic [7:0] row_cur, col_cur;
  logic       in_fire;
  logic       interior_cur, border_cur;
  logic [AddrW-1:0] rd_addr;

  // Memory return stage.
  logic             s1_valid_q;
  logic [3:0]       s1_cell_q;
  logic [7:0]       s1_row_q, s1_col_q;
  logic             s1_interior_q, s1_border_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [1:0]       s1_n;

  logic [7:0] mem_q [MemDepth];
  logic [7:0] rd_q;
  logic       fwd_q;
  logic [7:0] fwd_data_q;
  logic [7:0] line;
  logic [7:0] wr_data;
  logic [11:0] cur;
  logic [11:0] win0_q, win1_q;
  logic [3:0]  center, mark;
  logic        any_nz;

  assign row_cur = in_data_i.frame_start ? 8'd0 : row_q;
  assign col_cur = in_data_i.frame_start ? 8'd0 : col_q;
  assign rd_addr = col_cur[AddrW-1:0];

  assign interior_cur = (row_cur >= 8'd2) && (row_cur <= hm1) &&
                        (col_cur >= 8'd2) && (col_cur <= wm1);
  assign border_cur   = (row_cur == 8'd0) || (col_cur == 8'd0) ||
                        (row_cur >= hm1) || (col_cur >= wm1);

  // Hold off while the queue could not take this item's and the next item's results.
  assign s1_n = s1_valid_q ? {s1_interior_q & s1_border_q, s1_interior_q ^ s1_border_q}
                           : 2'd0;
  assign in_stall_o = ({1'b0, fifo_cnt_i} + {{(gobm_pkg::CNT_W-1){1'b0}}, s1_n})
                      > RoomLimit;
  assign in_fire = in_valid_i & ~in_stall_o;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (in_fire) begin
      if (col_cur >= wm1) begin
        col_d = 8'd0;
        row_d = (row_cur >= hm1) ? 8'd0 : row_cur + 8'd1;
      end else begin
        col_d = col_cur + 8'd1;
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      win0_q     <= '0;
      win1_q     <= '0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      s1_valid_q <= in_fire;
      // The read at this edge misses the write-back of the item ahead if both hit one entry.
      fwd_q      <= in_fire & s1_valid_q & (s1_addr_q == rd_addr);
      if (s1_valid_q) begin
        win0_q <= win1_q;
        win1_q <= cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cell_q     <= in_data_i.cell_req;
      s1_row_q      <= row_cur;
      s1_col_q      <= col_cur;
      s1_interior_q <= interior_cur;
      s1_border_q   <= border_cur;
      s1_addr_q     <= rd_addr;
      fwd_data_q    <= wr_data;
    end
  end

  // Line buffer: each entry holds the two previous rows, {row r-1, row r-2}.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      mem_q[s1_addr_q] <= wr_data;
    end
    if (in_fire) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign line    = fwd_q ? fwd_data_q : rd_q;
  assign wr_data = {s1_cell_q, line[7:4]};
  assign cur     = {s1_cell_q, line};

  assign center = win1_q[7:4];
  assign any_nz = (win0_q[3:0] != gobm_pkg::EMPTY_CODE) ||
                  (win0_q[7:4] != gobm_pkg::EMPTY_CODE) ||
                  (win0_q[11:8] != gobm_pkg::EMPTY_CODE) ||
                  (win1_q[3:0] != gobm_pkg::EMPTY_CODE) ||
                  (win1_q[11:8] != gobm_pkg::EMPTY_CODE) ||
                  (cur[3:0] != gobm_pkg::EMPTY_CODE) ||
                  (cur[7:4] != gobm_pkg::EMPTY_CODE) ||
                  (cur[11:8] != gobm_pkg::EMPTY_CODE);
  assign mark = ((center == gobm_pkg::EMPTY_CODE) && any_nz) ? gobm_pkg::WALL_CODE
                                                             : center;

  gobm_pkg::out_t res_inner, res_border;

  always_comb begin
    res_inner.out_row  = s1_row_q - 8'd1;
    res_inner.out_col  = s1_col_q - 8'd1;
    res_inner.out_cell = mark;
    res_inner.last     = ~s1_border_q;
    res_border.out_row  = s1_row_q;
    res_border.out_col  = s1_col_q;
    res_border.out_cell = s1_cell_q;
    res_border.last     = 1'b1;
  end

  assign push_o.count  = s1_n;
  assign push_o.first  = s1_interior_q ? res_inner : res_border;
  assign push_o.second = res_border;

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= ColLimit)
    else $error("column counter beyond line buffer depth");

  a_fwd_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> $past(in_fire && s1_valid_q))
    else $error("forwarding without overlapping accesses");

  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q || fifo_cnt_i != '0))
    else $error("input stalled with nothing pending");
`endif

endmodule

// ===== rtl/gobm_out_fifo.sv =====
// Output queue: takes up to two results a cycle, delivers one per transfer.
// Depends on gobm_pkg.
module gobm_out_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gobm_pkg::push_t            push_i,
  output logic [gobm_pkg::CNT_W-1:0] cnt_o,
  output logic                       out_valid_o,
  output gobm_pkg::out_t             out_data_o,
  input  logic                       out_stall_i
);

  localparam int unsigned PtrW = $clog2(gobm_pkg::FIFO_DEPTH);

  gobm_pkg::out_t ent_q [gobm_pkg::FIFO_DEPTH];
  logic [PtrW-1:0]           wptr_q, rptr_q;
  logic [gobm_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = ent_q[rptr_q];
  assign pop         = out_valid_o & ~out_stall_i;
  assign cnt_o       = cnt_q;
  assign cnt_d       = cnt_q + gobm_pkg::CNT_W'(push_i.count)
                             - gobm_pkg::CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + PtrW'(push_i.count);
      rptr_q <= rptr_q + PtrW'(pop);
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      ent_q[wptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      ent_q[wptr_q + PtrW'(1)] <= push_i.second;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= gobm_pkg::CNT_W'(gobm_pkg::FIFO_DEPTH))
    else $error("output queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cnt_q} + {{(gobm_pkg::CNT_W-1){1'b0}}, push_i.count})
      <= ((gobm_pkg::CNT_W + 1)'(gobm_pkg::FIFO_DEPTH) + {{gobm_pkg::CNT_W{1'b0}}, pop}))
    else $error("output queue overflow");

  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |=> out_valid_o)
    else $error("pushed result not offered");
`endif

endmodule

// ===== rtl/grid_outer_border_marker.sv =====
// Top level of the grid outer border marker.
// Depends on gobm_pkg, gobm_regs, gobm_scan and gobm_out_fifo.
//
// Usage:
// Cells arrive in raster order on the input channel, one per transfer; a set
// frame_start places that cell at row 0, column 0. Each cell causes zero, one
// or two results on the output channel: first the finished interior cell one
// row up and one column left (code 5 where an empty cell touches a filled one),
// then the cell itself when it lies on the grid border. The last flag is set
// on the final result of each input transfer.
// A cell accepted on the input is registered in the memory return stage,
// from which its results are pushed into the output queue. Throughput: one
// cell per cycle while the input is not stalled; the line buffer memory is
// read when a cell is accepted and written back in the following cycle, with
// forwarding when back-to-back cells hit the same column. The output side moves
// one result per transfer, so a cell with two results takes two transfers, and
// the input is stalled while queued results plus those of the cell in flight
// exceed two of the four queue entries.
// Reset clears the position counters, the window and the queue; grid size
// registers return to 175 by 175. A stalled receiver holds the head result
// while the queue fills, and the input is stalled before the queue can overflow.
module grid_outer_border_marker #(
  parameter int unsigned MAX_WIDTH = gobm_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  gobm_pkg::in_t               in_data_i,
  output logic                        in_stall_o,
  output logic                        out_valid_o,
  output gobm_pkg::out_t              out_data_o,
  input  logic                        out_stall_i,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gobm_pkg::CFG_AW-1:0] paddr,
  input  logic [gobm_pkg::CFG_DW-1:0] pwdata,
  output logic [gobm_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  gobm_pkg::cfg_t             cfg;
  gobm_pkg::push_t            push;
  logic [gobm_pkg::CNT_W-1:0] fifo_cnt;

  gobm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gobm_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .fifo_cnt_i (fifo_cnt),
    .push_o     (push)
  );

  gobm_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .cnt_o       (fifo_cnt),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== tb/gobm_checker.sv =====
// Checker for the grid outer border marker: watches both channels and the APB
// port, predicts every result of each cell transfer and compares them in order.
// Depends on gobm_pkg only.
module gobm_checker #(
  parameter int unsigned MAX_WIDTH = gobm_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  gobm_pkg::in_t               in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  gobm_pkg::out_t              out_data_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [gobm_pkg::CFG_AW-1:0] paddr_i,
  input  logic [gobm_pkg::CFG_DW-1:0] pwdata_i,
  output int unsigned                 error_count_o,
  output int unsigned                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIDTH_CAP = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;

  logic [gobm_pkg::SIZE_W-1:0] width_q;
  logic [gobm_pkg::SIZE_W-1:0] height_q;
  logic [3:0]                  line_prev  [MAX_WIDTH];
  logic [3:0]                  line_prev2 [MAX_WIDTH];
  logic [11:0]                 window_q   [2];
  logic [7:0]                  row_q;
  logic [7:0]                  col_q;
  gobm_pkg::out_t              expected_cells [$];

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      error_count_o++;
    end
  endtask

  task automatic predict_marks(input gobm_pkg::in_t item);
    int unsigned    eff_w;
    int unsigned    eff_h;
    int unsigned    idx;
    logic [7:0]     r;
    logic [7:0]     c;
    logic [11:0]    cur;
    logic [11:0]    column;
    logic [3:0]     center;
    logic           touched;
    gobm_pkg::out_t marks [2];
    int             n;
    eff_w = (width_q < gobm_pkg::SIZE_MIN) ? gobm_pkg::SIZE_MIN :
            (width_q > WIDTH_CAP) ? WIDTH_CAP : width_q;
    eff_h = (height_q < gobm_pkg::SIZE_MIN) ? gobm_pkg::SIZE_MIN :
            (height_q > gobm_pkg::HEIGHT_MAX) ? gobm_pkg::HEIGHT_MAX : height_q;
    if (item.frame_start) begin
      row_q = '0;
      col_q = '0;
    end
    r   = row_q;
    c   = col_q;
    idx = c % MAX_WIDTH;
    n   = 0;
    // Column of the window at the incoming cell: two rows up, one row up, this row.
    cur = {item.cell_req, line_prev[idx], line_prev2[idx]};

    if (r >= 2 && r <= eff_h - 1 && c >= 2 && c <= eff_w - 1) begin
      center  = window_q[1][7:4];
      touched = 1'b0;
      for (int i = 0; i < 3; i++) begin
        column = (i == 0) ? window_q[0] : (i == 1) ? window_q[1] : cur;
        for (int k = 0; k < 3; k++) begin
          if (!(i == 1 && k == 1) && column[4*k +: 4] != gobm_pkg::EMPTY_CODE) touched = 1'b1;
        end
      end
      marks[n] = '{out_row: r - 8'd1, out_col: c - 8'd1,
                   out_cell: (center == gobm_pkg::EMPTY_CODE && touched) ?
                             gobm_pkg::WALL_CODE : center,
                   last: 1'b0};
      n++;
    end
    // Anything at or past the last row or column is border, even after a resize.
    if (r == 0 || c == 0 || r >= eff_h - 1 || c >= eff_w - 1) begin
      marks[n] = '{out_row: r, out_col: c, out_cell: item.cell_req, last: 1'b0};
      n++;
    end
    if (n > 0) marks[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_cells.insert(expected_cells.size(), marks[i]);

    window_q[0]     = window_q[1];
    window_q[1]     = cur;
    line_prev2[idx] = line_prev[idx];
    line_prev[idx]  = item.cell_req;
    if (c >= eff_w - 1) begin
      col_q = '0;
      row_q = (r >= eff_h - 1) ? 8'd0 : r + 8'd1;
    end else begin
      col_q = c + 8'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gobm_pkg::out_t want;
    if (!rst_ni) begin
      width_q     = gobm_pkg::WIDTH_RST;
      height_q    = gobm_pkg::HEIGHT_RST;
      window_q[0] = '0;
      window_q[1] = '0;
      row_q       = '0;
      col_q       = '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        line_prev[i]  = '0;
        line_prev2[i] = '0;
      end
      expected_cells.delete();
      error_count_o = 0;
      pending_o     = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (gobm_pkg::reg_idx_e'(paddr_i[2]))
          gobm_pkg::REG_GRID_WIDTH:  width_q  = pwdata_i[gobm_pkg::SIZE_W-1:0];
          gobm_pkg::REG_GRID_HEIGHT: height_q = pwdata_i[gobm_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end
      // A result leaves the block only after its cell has been taken in, so compare first.
      if (out_valid_i && !out_stall_i) begin
        if (expected_cells.size() == 0) begin
          $error("unexpected result: row %0d col %0d cell %0d last %0d",
                 out_data_i.out_row, out_data_i.out_col, out_data_i.out_cell,
                 out_data_i.last);
          error_count_o++;
        end else begin
          want = expected_cells.pop_front();
          check_field("out_row", want.out_row, out_data_i.out_row);
          check_field("out_col", want.out_col, out_data_i.out_col);
          check_field("out_cell", 8'(want.out_cell), 8'(out_data_i.out_cell));
          check_field("last", 8'(want.last), 8'(out_data_i.last));
        end
      end
      if (in_valid_i && !in_stall_i) predict_marks(in_data_i);
      pending_o = expected_cells.size();
    end
  end

endmodule

// ===== tb/tb_grid_outer_border_marker.sv =====
// Top of the grid outer border marker testbench: clock, reset, cell and APB
// stimulus, random output stalls and the verdict. Depends on gobm_pkg, the
// block under test and gobm_checker.
module tb_grid_outer_border_marker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TOTAL_ITEMS = 1550;
  localparam int unsigned QUIET_AT    = 1400;
  localparam int unsigned HOLD_AT     = 300;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned STALL_LIMIT = 1000;

  // 3x3 frames, cell i in bits 4*i+3:4*i in raster order.
  // The first has an empty center between two filled corners, the second an
  // empty center next to one filled edge cell.
  localparam logic [35:0] CORNER_FRAME = 36'hF00000008;
  localparam logic [35:0] EDGE_FRAME   = 36'h000200000;

  logic                        clk_i;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  gobm_pkg::in_t               in_data_i   = '0;
  logic                        in_stall_o;
  logic                        out_valid_o;
  gobm_pkg::out_t              out_data_o;
  logic                        out_stall_i = 1'b0;
  logic                        psel        = 1'b0;
  logic                        penable     = 1'b0;
  logic                        pwrite      = 1'b0;
  logic [gobm_pkg::CFG_AW-1:0] paddr       = '0;
  logic [gobm_pkg::CFG_DW-1:0] pwdata      = '0;
  logic [gobm_pkg::CFG_DW-1:0] prdata;
  logic                        pready;
  int unsigned                 error_count;
  int unsigned                 pending;
  int unsigned                 items_sent  = 0;

  grid_outer_border_marker u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  gobm_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic send_cell(input logic [3:0] code, input logic first);
    gobm_pkg::in_t item;
    bit            taken;
    if (items_sent < QUIET_AT && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    item.cell_req    = code;
    item.frame_start = first;
    in_data_i  <= item;
    in_valid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    items_sent++;
  endtask

  // Density 0 gives an empty area, 4 a completely filled one.
  task automatic send_cells(input int unsigned count, input bit start_frame,
                            input int unsigned density, input bit noisy);
    logic [3:0] code;
    logic       first;
    for (int unsigned i = 0; i < count; i++) begin
      code  = ($urandom_range(0, 3) < density) ? 4'($urandom_range(1, 15))
                                               : gobm_pkg::EMPTY_CODE;
      first = (i == 0 && start_frame) || (noisy && $urandom_range(0, 199) == 0);
      send_cell(code, first);
    end
  endtask

  // Register writes are only safe once every result is out and the last cell,
  // which may have had no result at all, has left the pipeline.
  task automatic finish_phase();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input gobm_pkg::reg_idx_e idx,
                           input logic [gobm_pkg::SIZE_W-1:0] value);
    logic [gobm_pkg::CFG_DW-1:0] word;
    word = $urandom;
    word[gobm_pkg::SIZE_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned cur_w;
    int unsigned raw_w;
    int unsigned raw_h;
    int unsigned next_w;
    int unsigned next_h;
    int unsigned span;
    bit          keep_position;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(gobm_pkg::REG_GRID_WIDTH, 9'd3);
    write_reg(gobm_pkg::REG_GRID_HEIGHT, 9'd3);
    for (int i = 0; i < 9; i++) send_cell(CORNER_FRAME[4*i +: 4], i == 0);
    // A frame cut short by a new frame start in its second row.
    for (int i = 0; i < 4; i++) send_cell(4'hF, i == 0);
    for (int i = 0; i < 9; i++) send_cell(EDGE_FRAME[4*i +: 4], i == 0);

    // Tallest grid, three columns wide, run through to the row wrap.
    finish_phase();
    write_reg(gobm_pkg::REG_GRID_WIDTH, 9'd0);
    write_reg(gobm_pkg::REG_GRID_HEIGHT, 9'd256);
    send_cells(768, 1'b1, $urandom_range(1, 3), 1'b0);

    // Widest grid, clamped from the largest register value. Two full rows fill
    // every line buffer column, then part of the third row follows.
    finish_phase();
    write_reg(gobm_pkg::REG_GRID_WIDTH, 9'd511);
    write_reg(gobm_pkg::REG_GRID_HEIGHT, 9'd1);
    send_cells(600, 1'b1, $urandom_range(1, 3), 1'b0);
    cur_w = 256;

    while (items_sent < TOTAL_ITEMS) begin
      raw_w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      case ($urandom_range(0, 9))
        0:       raw_h = $urandom_range(0, 2);
        1:       raw_h = $urandom_range(257, 511);
        default: raw_h = $urandom_range(3, 10);
      endcase
      next_w = (raw_w < 3) ? 3 : raw_w;
      next_h = (raw_h < 3) ? 3 : (raw_h > 256) ? 256 : raw_h;
      // Carrying on without a frame start is only safe when the width does not
      // grow, since wider rows would reach line buffer columns never filled.
      keep_position = (next_w <= cur_w) && ($urandom_range(0, 2) == 0);
      finish_phase();
      write_reg(gobm_pkg::REG_GRID_WIDTH, gobm_pkg::SIZE_W'(raw_w));
      write_reg(gobm_pkg::REG_GRID_HEIGHT, gobm_pkg::SIZE_W'(raw_h));
      cur_w = next_w;
      repeat ($urandom_range(1, 3)) begin
        if (items_sent < TOTAL_ITEMS) begin
          span = next_w * next_h;
          if (span > 150) span = 150;
          if (span > TOTAL_ITEMS - items_sent) span = TOTAL_ITEMS - items_sent;
          if ($urandom_range(0, 5) == 0) span = $urandom_range(1, span);
          send_cells(span, !keep_position, $urandom_range(0, 4), 1'b1);
          keep_position = 1'b0;
        end
      end
    end

    finish_phase();
    repeat (16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : receiver
    bit held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && items_sent >= HOLD_AT) begin
        // Long hold so the output queue fills and the input side stalls.
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (items_sent < QUIET_AT && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    wait (rst_ni);
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gobm_pkg.sv
rtl/gobm_regs.sv
rtl/gobm_scan.sv
rtl/gobm_out_fifo.sv
rtl/grid_outer_border_marker.sv
tb/gobm_checker.sv
tb/tb_grid_outer_border_marker.sv
